>>> hw/rtl/gre_pkg.sv
// Shared definitions for the graph reachability engine.
// Used by graph_reachability_engine; no dependencies.
`default_nettype none

package gre_pkg;

    localparam int VERTEX_W         = 6;
    localparam int MAX_VERTICES     = 1 << VERTEX_W;
    localparam int NUM_VERTICES_DEF = 64;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WA,
        ST_ADD_WB,
        ST_QRUN
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/gre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No package dependency; read during write to the same address returns old data.
`default_nettype none

module gre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gre_pick.sv
// Lowest-set-bit picker over the pending vertex set.
// Gives the one-hot of the lowest set bit and its index; no package dependency.
`default_nettype none

module gre_pick #(
    parameter int N = 64
) (
    input  wire logic [N-1:0]         i_set,
    output logic                      o_any,
    output logic [N-1:0]              o_lowest,
    output logic [$clog2(N)-1:0]      o_idx
);

    localparam int IW = $clog2(N);

    always_comb begin
        o_any    = |i_set;
        o_lowest = i_set & (~i_set + {{(N-1){1'b0}}, 1'b1});
        o_idx    = '0;
        for (int i = 0; i < N; i++) begin
            if (o_lowest[i]) begin
                o_idx = o_idx | IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/graph_reachability_engine.sv
// Top level of the graph reachability engine: adjacency RAM, control FSM.
// Depends on gre_pkg, gre_ram and gre_pick.
//
// Usage:
//   An item (opcode, vertex_a, vertex_b) is taken at a rising edge with start
//   high and busy low. Every item yields exactly one result, shown for one
//   cycle with o_strobe high; the receiver cannot stall it.
//   Add edge: when both ends are in range, a read-modify-write of row a, then
//   of row b, in the adjacency RAM (one write port); otherwise only an ack.
//   Query: answered without a walk when source equals destination or a vertex
//   is out of range. Otherwise one adjacency row is read per newly reached
//   vertex. Reads follow each other every cycle while vertices are pending;
//   when a row returns with nothing else pending, the next read waits until
//   the vertices it adds are registered as pending. The walk stops early when
//   the destination is found.
//   busy is high while rows are written or a walk runs; items needing neither
//   keep busy low. The result strobe comes in the first cycle with busy low
//   again (the cycle after start when busy never rose).
//   Reset: a clearing pass writes every adjacency row to zero, one row per
//   cycle; busy is high during it.
//   Vertex fields are 6 bits wide, so at most 64 vertices are stored.
`default_nettype none

module graph_reachability_engine
    import gre_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_opcode,
    input  wire logic [VERTEX_W-1:0] i_vertex_a,
    input  wire logic [VERTEX_W-1:0] i_vertex_b,
    output logic                     o_strobe,
    output logic                     o_is_answer,
    output logic                     o_reachable
);

    localparam int NV    = (NUM_VERTICES < MAX_VERTICES) ? NUM_VERTICES : MAX_VERTICES;
    localparam int IDX_W = $clog2(NV);
    localparam logic [NV-1:0] ONE = {{(NV-1){1'b0}}, 1'b1};

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr_cnt, n_clr_cnt;
    logic              r_inflight, n_inflight;
    logic              r_out_stb, n_out_stb;
    logic              r_out_ans, n_out_ans;
    logic              r_out_reach, n_out_reach;
    logic [NV-1:0]     r_seen, n_seen;
    logic [NV-1:0]     r_pend, n_pend;
    logic [IDX_W-1:0]  r_va, n_va;
    logic [IDX_W-1:0]  r_vb, n_vb;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [NV-1:0]     ram_wdata, ram_rdata;

    logic              pick_any;
    logic [NV-1:0]     pick_lowest;
    logic [IDX_W-1:0]  pick_idx;

    logic              accept, a_ok, b_ok;
    logic [NV-1:0]     fresh;

    gre_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gre_pick #(.N(NV)) u_pick (
        .i_set    (r_pend),
        .o_any    (pick_any),
        .o_lowest (pick_lowest),
        .o_idx    (pick_idx)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign a_ok        = (int'(i_vertex_a) < NUM_VERTICES);
    assign b_ok        = (int'(i_vertex_b) < NUM_VERTICES);
    assign o_strobe    = r_out_stb;
    assign o_is_answer = r_out_ans;
    assign o_reachable = r_out_reach;

    // neighbors of the row read last cycle that are not yet reached
    assign fresh = r_inflight ? (ram_rdata & ~r_seen) : '0;

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_inflight  = 1'b0;
        n_out_stb   = 1'b0;
        n_out_ans   = r_out_ans;
        n_out_reach = r_out_reach;
        n_seen      = r_seen;
        n_pend      = r_pend;
        n_va        = r_va;
        n_vb        = r_vb;
        ram_we      = 1'b0;
        ram_waddr   = r_va;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_va;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == IDX_W'(NV - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_va = i_vertex_a[IDX_W-1:0];
                    n_vb = i_vertex_b[IDX_W-1:0];
                    if (t_opcode'(i_opcode) == OP_ADD) begin
                        if (a_ok && b_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = i_vertex_a[IDX_W-1:0];
                            n_state   = ST_ADD_WA;
                        end else begin
                            n_out_stb   = 1'b1;
                            n_out_ans   = 1'b0;
                            n_out_reach = 1'b0;
                        end
                    end else if (i_vertex_a == i_vertex_b) begin
                        n_out_stb   = 1'b1;
                        n_out_ans   = 1'b1;
                        n_out_reach = 1'b1;
                    end else if (!(a_ok && b_ok)) begin
                        n_out_stb   = 1'b1;
                        n_out_ans   = 1'b1;
                        n_out_reach = 1'b0;
                    end else begin
                        n_seen  = ONE << i_vertex_a[IDX_W-1:0];
                        n_pend  = ONE << i_vertex_a[IDX_W-1:0];
                        n_state = ST_QRUN;
                    end
                end
            end
            ST_ADD_WA: begin
                // row b is read while row a is written; when a equals b both
                // writes set the same bit, so the stale read is harmless
                ram_we    = 1'b1;
                ram_waddr = r_va;
                ram_wdata = ram_rdata | (ONE << r_vb);
                ram_re    = 1'b1;
                ram_raddr = r_vb;
                n_state   = ST_ADD_WB;
            end
            ST_ADD_WB: begin
                ram_we      = 1'b1;
                ram_waddr   = r_vb;
                ram_wdata   = ram_rdata | (ONE << r_va);
                n_out_stb   = 1'b1;
                n_out_ans   = 1'b0;
                n_out_reach = 1'b0;
                n_state     = ST_IDLE;
            end
            ST_QRUN: begin
                n_seen = r_seen | fresh;
                if (pick_any) begin
                    ram_re     = 1'b1;
                    ram_raddr  = pick_idx;
                    n_inflight = 1'b1;
                    n_pend     = (r_pend & ~pick_lowest) | fresh;
                end else begin
                    n_pend = fresh;
                end
                priority if (fresh[r_vb]) begin
                    n_out_stb   = 1'b1;
                    n_out_ans   = 1'b1;
                    n_out_reach = 1'b1;
                    n_inflight  = 1'b0;
                    n_state     = ST_IDLE;
                end else if (!r_inflight && !pick_any) begin
                    n_out_stb   = 1'b1;
                    n_out_ans   = 1'b1;
                    n_out_reach = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    n_state     = ST_QRUN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_cnt  <= '0;
            r_inflight <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_inflight <= n_inflight;
            r_out_stb  <= n_out_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ans   <= n_out_ans;
        r_out_reach <= n_out_reach;
        r_seen      <= n_seen;
        r_pend      <= n_pend;
        r_va        <= n_va;
        r_vb        <= n_vb;
    end

    // during a walk, pending vertices are always already marked reached
    a_pend_in_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QRUN) |-> ((r_pend & ~r_seen) == '0))
        else $error("pending vertex not marked reached");

    // a row read is only in flight during a walk
    a_inflight_qrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> (r_state == ST_QRUN))
        else $error("row read in flight outside a walk");

    // self query answers 1 in the next cycle
    a_self_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_QUERY) && (i_vertex_a == i_vertex_b))
        |=> (o_strobe && o_is_answer && o_reachable))
        else $error("self query not answered 1");

    // the second row write ends an add with an acknowledgement
    a_add_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD_WB) |=> (o_strobe && !o_is_answer && !o_reachable))
        else $error("add edge not acknowledged");

    // no result strobe while the clearing pass runs
    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_strobe)
        else $error("result during clearing pass");

endmodule

`default_nettype wire
